/* design/snake_matrix_search_defines.svh */
// ----------------------------------------------------------------------------
// snake_matrix_search_defines
// Assertion macros for the matrix search block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SNAKE_MATRIX_SEARCH_DEFINES_SVH
`define SNAKE_MATRIX_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define SMR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("snake_matrix_search: same-cycle check failed");
`define SMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("snake_matrix_search: next-cycle check failed");
`else
`define SMR_ASSERT_NOW(lbl, ante, cons)
`define SMR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/smr_pkg.sv */
// ----------------------------------------------------------------------------
// smr_pkg
// Types and fixed constants shared by the matrix search block.
// ----------------------------------------------------------------------------
package smr_pkg;

  localparam int WORD_W     = 32;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 6;
  localparam int ROWS_CFG_W = 5;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PROBE  = 3'b010,
    ST_FINISH = 3'b100
  } smr_state_t;

endpackage

/* design/smr_store.sv */
// ----------------------------------------------------------------------------
// smr_store
// Matrix word memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smr_store #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [smr_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [smr_pkg::WORD_W-1:0] rd_data
);

  logic [smr_pkg::WORD_W-1:0] mem [DEPTH];
  logic [smr_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/snake_matrix_search.sv */
// ----------------------------------------------------------------------------
// snake_matrix_search
// Row-by-row binary search over a snake-sorted matrix of signed words.
// ----------------------------------------------------------------------------
// A request with in_opcode low writes one matrix word in the cycle it is taken
// and leaves busy low. A request with in_opcode high searches rows 0 to
// rows_in_use-1, even rows descending and odd rows ascending, and reports one
// result per row holding the target, or a single not-found result. Each result
// shows on out_valid for exactly one cycle and cannot be held off; out_last
// marks the final one. A hit is kept back until the next hit or the end of the
// search so its last flag is known. The memory read port gives one word per
// cycle and each probe's compare picks the next read address; a row takes at
// most ceil(log2(cols + 1)) probes. The memory is not cleared after reset;
// only written words may be searched.
// ----------------------------------------------------------------------------
module snake_matrix_search #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic [smr_pkg::ROW_W-1:0]        in_row_addr,
  input  logic [smr_pkg::COL_W-1:0]        in_col_addr,
  input  logic signed [smr_pkg::WORD_W-1:0] in_value,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [smr_pkg::ROW_W-1:0]        out_row,
  output logic [smr_pkg::COL_W-1:0]        out_col,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

`include "snake_matrix_search_defines.svh"

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [smr_pkg::ROWS_CFG_W-1:0] ROWS_TOP =
    (MAX_ROWS > 31) ? 5'd31 : 5'(MAX_ROWS);
  localparam logic [smr_pkg::COLS_CFG_W-1:0] COLS_TOP =
    (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);

  smr_pkg::smr_state_t state_r, state_nxt;

  logic [smr_pkg::ROWS_CFG_W-1:0] rows_cfg_r;
  logic [smr_pkg::COLS_CFG_W-1:0] cols_cfg_r;

  logic signed [smr_pkg::WORD_W-1:0] target_r, target_nxt;
  logic [smr_pkg::ROWS_CFG_W-1:0] nrows_r, nrows_nxt;
  logic [smr_pkg::ROWS_CFG_W-1:0] row_r, row_nxt;
  logic [AW-1:0]                  row_base_r, row_base_nxt;
  logic [7:0]                     lo_r, lo_nxt;
  logic [7:0]                     hi_r, hi_nxt;
  logic [7:0]                     hi_init_r, hi_init_nxt;
  logic [6:0]                     mid_r, mid_nxt;
  logic [6:0]                     mid0_r, mid0_nxt;
  logic                           pend_vld_r, pend_vld_nxt;
  logic [smr_pkg::ROW_W-1:0]      pend_row_r, pend_row_nxt;
  logic [smr_pkg::COL_W-1:0]      pend_col_r, pend_col_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [smr_pkg::ROW_W-1:0]      out_row_r, out_row_nxt;
  logic [smr_pkg::COL_W-1:0]      out_col_r, out_col_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           load_acc, query_acc, wr_en, rd_en;
  logic [AW-1:0]                  wr_addr, rd_addr;
  logic [smr_pkg::WORD_W-1:0]     rd_data;
  logic [smr_pkg::ROWS_CFG_W-1:0] nrows_eff;
  logic [smr_pkg::COLS_CFG_W-1:0] ncols_eff, ncols_m1;
  logic [7:0]                     mid8, lo_step, hi_step, span, mid_step8;
  logic                           elem_eq, elem_gt, go_right, more, last_row;

  assign busy      = (state_r != smr_pkg::ST_IDLE);
  assign load_acc  = start && !busy && (in_opcode == smr_pkg::OP_LOAD);
  assign query_acc = start && !busy && (in_opcode == smr_pkg::OP_QUERY);
  assign wr_en     = load_acc && (32'(in_row_addr) < MAX_ROWS) && (32'(in_col_addr) < MAX_COLS);
  assign wr_addr   = AW'(32'(in_row_addr) * MAX_COLS + 32'(in_col_addr));

  // clamp the written register values into their usable ranges
  assign nrows_eff = (rows_cfg_r == '0) ? 5'd1 :
                     (rows_cfg_r > ROWS_TOP) ? ROWS_TOP : rows_cfg_r;
  assign ncols_eff = (cols_cfg_r == '0) ? 7'd1 :
                     (cols_cfg_r > COLS_TOP) ? COLS_TOP : cols_cfg_r;
  assign ncols_m1  = ncols_eff - 7'd1;

  // probe decision
  assign mid8      = {1'b0, mid_r};
  assign elem_eq   = ($signed(rd_data) == target_r);
  assign elem_gt   = ($signed(rd_data) > target_r);
  assign go_right  = (elem_gt == !row_r[0]);
  assign lo_step   = go_right ? (mid8 + 8'd1) : lo_r;
  assign hi_step   = go_right ? hi_r : (mid8 - 8'd1);
  assign more      = !elem_eq && ($signed(lo_step) <= $signed(hi_step));
  assign span      = hi_step - lo_step;
  assign mid_step8 = lo_step + {1'b0, span[7:1]};
  assign last_row  = ((6'(row_r) + 6'd1) == 6'(nrows_r));

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    nrows_nxt     = nrows_r;
    row_nxt       = row_r;
    row_base_nxt  = row_base_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    hi_init_nxt   = hi_init_r;
    mid_nxt       = mid_r;
    mid0_nxt      = mid0_r;
    pend_vld_nxt  = pend_vld_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = 1'b0;
    out_row_nxt   = '0;
    out_col_nxt   = '0;
    out_last_nxt  = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    case (state_r)
      smr_pkg::ST_IDLE: begin
        if (query_acc) begin
          target_nxt   = in_value;
          nrows_nxt    = nrows_eff;
          row_nxt      = '0;
          row_base_nxt = '0;
          lo_nxt       = '0;
          hi_nxt       = {1'b0, ncols_m1};
          hi_init_nxt  = {1'b0, ncols_m1};
          mid_nxt      = {1'b0, ncols_m1[6:1]};
          mid0_nxt     = {1'b0, ncols_m1[6:1]};
          pend_vld_nxt = 1'b0;
          rd_en        = 1'b1;
          rd_addr      = AW'({1'b0, ncols_m1[6:1]});
          state_nxt    = smr_pkg::ST_PROBE;
        end
      end
      smr_pkg::ST_PROBE: begin
        if (more) begin
          lo_nxt  = lo_step;
          hi_nxt  = hi_step;
          mid_nxt = mid_step8[6:0];
          rd_en   = 1'b1;
          rd_addr = row_base_r + AW'(mid_step8[6:0]);
        end else begin
          if (elem_eq) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b1;
              out_row_nxt   = pend_row_r;
              out_col_nxt   = pend_col_r;
            end
            pend_vld_nxt = 1'b1;
            pend_row_nxt = row_r[smr_pkg::ROW_W-1:0];
            pend_col_nxt = mid_r[smr_pkg::COL_W-1:0];
          end
          if (last_row) begin
            state_nxt = smr_pkg::ST_FINISH;
          end else begin
            row_nxt      = row_r + 5'd1;
            row_base_nxt = row_base_r + AW'(MAX_COLS);
            lo_nxt       = '0;
            hi_nxt       = hi_init_r;
            mid_nxt      = mid0_r;
            rd_en        = 1'b1;
            rd_addr      = row_base_r + AW'(MAX_COLS) + AW'(mid0_r);
          end
        end
      end
      smr_pkg::ST_FINISH: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (pend_vld_r) begin
          out_found_nxt = 1'b1;
          out_row_nxt   = pend_row_r;
          out_col_nxt   = pend_col_r;
        end
        state_nxt = smr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = smr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      rows_cfg_r  <= ROWS_TOP;
      cols_cfg_r  <= COLS_TOP;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
      if (cfg_we && (cfg_index == smr_pkg::CFG_ROWS)) begin
        rows_cfg_r <= cfg_wdata[smr_pkg::ROWS_CFG_W-1:0];
      end
      if (cfg_we && (cfg_index == smr_pkg::CFG_COLS)) begin
        cols_cfg_r <= cfg_wdata[smr_pkg::COLS_CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    nrows_r     <= nrows_nxt;
    row_r       <= row_nxt;
    row_base_r  <= row_base_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    hi_init_r   <= hi_init_nxt;
    mid_r       <= mid_nxt;
    mid0_r      <= mid0_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_col_r  <= pend_col_nxt;
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_last_r  <= out_last_nxt;
  end

  smr_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

  `SMR_ASSERT_NOW(a_out_from_search, out_valid, $past(state_r == smr_pkg::ST_PROBE) || $past(state_r == smr_pkg::ST_FINISH))
  `SMR_ASSERT_NOW(a_miss_shape, out_valid && !out_found, out_last && (out_row == '0) && (out_col == '0))
  `SMR_ASSERT_NOW(a_search_from_query, (state_r == smr_pkg::ST_PROBE) && $past(state_r == smr_pkg::ST_IDLE), $past(start) && $past(in_opcode == smr_pkg::OP_QUERY))
  `SMR_ASSERT_NOW(a_probe_window, state_r == smr_pkg::ST_PROBE, ($signed(lo_r) <= $signed(mid8)) && ($signed(mid8) <= $signed(hi_r)))
  `SMR_ASSERT_NEXT(a_finish_reports, state_r == smr_pkg::ST_FINISH, (state_r == smr_pkg::ST_IDLE) && out_valid && out_last)

endmodule
